// File: hdl/ecpu_pkg.sv
// ----------------------------------------------------------------------------
// ecpu_pkg
// Shared types, codes and helpers of the 8-bit CPU instruction step unit.
// ----------------------------------------------------------------------------
package ecpu_pkg;

  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  localparam int unsigned F_CY = 0;
  localparam int unsigned F_P  = 1;
  localparam int unsigned F_AC = 2;
  localparam int unsigned F_Z  = 3;
  localparam int unsigned F_S  = 4;

  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_SHLD      = 8'h22;
  localparam logic [7:0] OP_LHLD      = 8'h2A;
  localparam logic [7:0] OP_HLT       = 8'h76;
  localparam logic [7:0] OP_LO_END    = 8'h40;
  localparam logic [7:0] OP_ALU_START = 8'h80;
  localparam logic [7:0] OP_UNSUP     = 8'h98;

  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_HALTED = 2'd1,
    ST_UNSUP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ASEL_IN  = 3'd0,
    ASEL_PC  = 3'd1,
    ASEL_PC1 = 3'd2,
    ASEL_PC2 = 3'd3,
    ASEL_D   = 3'd4,
    ASEL_D1  = 3'd5
  } asel_e;

  typedef struct packed {
    logic  accept;
    logic  wr_in;
    asel_e asel;
    logic  lat_op;
    logic  lat_imm_lo;
    logic  lat_imm_hi;
    logic  lat_dat_lo;
    logic  lat_dat_hi;
    logic  lat_rd;
    logic  exec;
    logic  wr2;
  } ecpu_cmd_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic halted;
    logic need_imm2;
    logic need_drd;
    logic need_drd2;
    logic need_wr2;
  } ecpu_stat_t;

  localparam int unsigned RES_BITS = 112;

  // update sign, zero and parity from a result byte
  function automatic logic [4:0] set_szp(logic [4:0] f, logic [7:0] v);
    logic [4:0] r;
    r       = f;
    r[F_S]  = v[7];
    r[F_Z]  = (v == 8'h00);
    r[F_P]  = ~^v;
    return r;
  endfunction

endpackage

// File: hdl/ecpu_ctrl.sv
// ----------------------------------------------------------------------------
// ecpu_ctrl
// Sequencer: steps one item through fetch, operand reads, execute, result, or through a memory write or read.
// ----------------------------------------------------------------------------
module ecpu_ctrl import ecpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  ecpu_stat_t stat_i,
  output ecpu_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MWRITE = 14'b00000000000010,
    S_MREAD  = 14'b00000000000100,
    S_MRDW   = 14'b00000000001000,
    S_FETCH  = 14'b00000000010000,
    S_DEC    = 14'b00000000100000,
    S_IMM1   = 14'b00000001000000,
    S_IMM2   = 14'b00000010000000,
    S_DRD    = 14'b00000100000000,
    S_DRDW   = 14'b00001000000000,
    S_DRD2W  = 14'b00010000000000,
    S_EXEC   = 14'b00100000000000,
    S_WR2    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.asel = ASEL_PC;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i) begin
          unique case (stat_i.in_cmd)
            CMD_EXEC:  state_d = stat_i.halted ? S_DONE : S_FETCH;
            CMD_WRITE: state_d = S_MWRITE;
            CMD_READ:  state_d = S_MREAD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_MWRITE: begin
        cmd_o.asel  = ASEL_IN;
        cmd_o.wr_in = 1'b1;
        state_d     = S_DONE;
      end
      S_MREAD: begin
        cmd_o.asel = ASEL_IN;
        state_d    = S_MRDW;
      end
      S_MRDW: begin
        cmd_o.lat_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_FETCH: begin
        cmd_o.asel = ASEL_PC;
        state_d    = S_DEC;
      end
      S_DEC: begin
        cmd_o.lat_op = 1'b1;
        cmd_o.asel   = ASEL_PC1;
        state_d      = S_IMM1;
      end
      S_IMM1: begin
        cmd_o.lat_imm_lo = 1'b1;
        cmd_o.asel       = ASEL_PC2;
        if (stat_i.need_imm2) begin
          state_d = S_IMM2;
        end else if (stat_i.need_drd) begin
          state_d = S_DRD;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_IMM2: begin
        cmd_o.lat_imm_hi = 1'b1;
        state_d = stat_i.need_drd ? S_DRD : S_EXEC;
      end
      S_DRD: begin
        cmd_o.asel = ASEL_D;
        state_d    = S_DRDW;
      end
      S_DRDW: begin
        cmd_o.lat_dat_lo = 1'b1;
        cmd_o.asel       = ASEL_D1;
        state_d = stat_i.need_drd2 ? S_DRD2W : S_EXEC;
      end
      S_DRD2W: begin
        cmd_o.lat_dat_hi = 1'b1;
        state_d          = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.asel = ASEL_D;
        state_d = stat_i.need_wr2 ? S_WR2 : S_DONE;
      end
      S_WR2: begin
        cmd_o.wr2  = 1'b1;
        cmd_o.asel = ASEL_D1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hdl/ecpu_dp.sv
// ----------------------------------------------------------------------------
// ecpu_dp
// Datapath: architectural registers, byte memory, decode and execute logic.
// ----------------------------------------------------------------------------
module ecpu_dp import ecpu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic [1:0]          in_cmd_i,
  input  logic [15:0]         in_addr_i,
  input  logic [7:0]          in_byte_i,
  input  ecpu_cmd_t           cmd_i,
  output ecpu_stat_t          stat_o,
  output logic [RES_BITS-1:0] res_o
);

  logic [15:0] pc_q, sp_q;
  logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
  logic [4:0]  f_q;
  logic        halt_q, trap_q;

  logic [15:0] addr_q;
  logic [7:0]  wb_q, op_q, rdata_q, rd_q;
  logic [15:0] imm_q, dat_q;
  logic [4:0]  cyc_q;
  status_e     st_q;

  logic [7:0]  mem [MEM_DEPTH];

  // decode
  logic [2:0] lo3, dst, src_i;
  logic [1:0] rp;
  logic       odd, grp_lo, grp_mov, grp_alu, unsup;
  logic [15:0] rp_val, hl, daddr;
  logic [7:0]  src8;

  assign lo3     = op_q[2:0];
  assign dst     = op_q[5:3];
  assign rp      = op_q[5:4];
  assign odd     = op_q[3];
  assign grp_lo  = op_q < OP_LO_END;
  assign grp_mov = op_q[7:6] == 2'b01;
  assign grp_alu = (op_q >= OP_ALU_START) && (op_q < OP_UNSUP);
  assign unsup   = (op_q >= OP_UNSUP) ||
                   (grp_lo && lo3 == 3'd0 && op_q != OP_NOP && trap_q);
  assign hl      = {h_q, l_q};
  assign src_i   = grp_lo ? dst : lo3;

  always_comb begin
    case (rp)
      2'd0:    rp_val = {b_q, c_q};
      2'd1:    rp_val = {d_q, e_q};
      2'd2:    rp_val = hl;
      default: rp_val = sp_q;
    endcase
    case (src_i)
      3'd0:    src8 = b_q;
      3'd1:    src8 = c_q;
      3'd2:    src8 = d_q;
      3'd3:    src8 = e_q;
      3'd4:    src8 = h_q;
      3'd5:    src8 = l_q;
      REG_M:   src8 = dat_q[7:0];
      default: src8 = a_q;
    endcase
    if (grp_lo && lo3 == 3'd2) begin
      daddr = rp[1] ? imm_q : rp_val;
    end else begin
      daddr = hl;
    end
  end

  assign stat_o.in_cmd    = cmd_e'(in_cmd_i);
  assign stat_o.halted    = halt_q;
  assign stat_o.need_imm2 = grp_lo && ((lo3 == 3'd1 && !odd) || (lo3 == 3'd2 && rp[1]));
  assign stat_o.need_drd  = !unsup &&
                            ((grp_lo && lo3 == 3'd2 && odd) ||
                             (grp_lo && (lo3 == 3'd4 || lo3 == 3'd5) && dst == REG_M) ||
                             (grp_mov && lo3 == REG_M && op_q != OP_HLT) ||
                             (grp_alu && lo3 == REG_M));
  assign stat_o.need_drd2 = op_q == OP_LHLD;
  assign stat_o.need_wr2  = op_q == OP_SHLD;

  // execute
  logic [15:0] pc_n, sp_n;
  logic [7:0]  a_n, b_n, c_n, d_n, e_n, h_n, l_n;
  logic [4:0]  f_n, cyc_n;
  logic        halt_n, ex_we;
  logic [7:0]  ex_wv;

  always_comb begin
    logic [1:0]  len;
    logic        rw_en, pw_en;
    logic [2:0]  rw_i;
    logic [7:0]  rw_v, v;
    logic [1:0]  pw_i;
    logic [15:0] pw_v;
    logic [16:0] s17;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [7:0]  corr;
    logic        cy, cin;
    len    = 2'd1;
    cyc_n  = 5'd4;
    pc_n   = pc_q;
    sp_n   = sp_q;
    a_n    = a_q;
    b_n    = b_q;
    c_n    = c_q;
    d_n    = d_q;
    e_n    = e_q;
    h_n    = h_q;
    l_n    = l_q;
    f_n    = f_q;
    halt_n = halt_q;
    ex_we  = 1'b0;
    ex_wv  = a_q;
    rw_en  = 1'b0;
    rw_i   = dst;
    rw_v   = 8'h00;
    pw_en  = 1'b0;
    pw_i   = rp;
    pw_v   = 16'h0000;
    v      = 8'h00;
    s17    = '0;
    s9     = '0;
    s5     = '0;
    corr   = 8'h00;
    cy     = f_q[F_CY];
    cin    = 1'b0;
    if (grp_lo) begin
      case (lo3)
        3'd0: ;
        3'd1: begin
          cyc_n = 5'd10;
          pw_en = 1'b1;
          if (!odd) begin
            pw_v = imm_q;
            len  = 2'd3;
          end else begin
            s17        = {1'b0, hl} + {1'b0, rp_val};
            f_n[F_CY]  = s17[16];
            pw_i       = 2'd2;
            pw_v       = s17[15:0];
          end
        end
        3'd2: begin
          if (!rp[1]) begin
            cyc_n = 5'd7;
          end else begin
            len   = 2'd3;
            cyc_n = rp[0] ? 5'd13 : 5'd16;
          end
          if (rp == 2'd2) begin
            if (odd) begin
              l_n = dat_q[7:0];
              h_n = dat_q[15:8];
            end else begin
              ex_we = 1'b1;
              ex_wv = l_q;
            end
          end else if (odd) begin
            a_n = dat_q[7:0];
          end else begin
            ex_we = 1'b1;
            ex_wv = a_q;
          end
        end
        3'd3: begin
          cyc_n = 5'd5;
          pw_en = 1'b1;
          pw_v  = odd ? rp_val - 16'd1 : rp_val + 16'd1;
        end
        3'd4, 3'd5: begin
          cyc_n = (dst == REG_M) ? 5'd10 : 5'd5;
          if (lo3 == 3'd4) begin
            f_n[F_AC] = src8[3:0] == 4'hF;
            v         = src8 + 8'd1;
          end else begin
            f_n[F_AC] = src8[3:0] != 4'h0;
            v         = src8 - 8'd1;
          end
          f_n   = set_szp(f_n, v);
          rw_en = 1'b1;
          rw_v  = v;
        end
        3'd6: begin
          len   = 2'd2;
          cyc_n = (dst == REG_M) ? 5'd10 : 5'd7;
          rw_en = 1'b1;
          rw_v  = imm_q[7:0];
        end
        default: begin
          case (dst)
            3'd0: begin
              f_n[F_CY] = a_q[7];
              a_n       = {a_q[6:0], a_q[7]};
            end
            3'd1: begin
              f_n[F_CY] = a_q[0];
              a_n       = {a_q[0], a_q[7:1]};
            end
            3'd2: begin
              f_n[F_CY] = a_q[7];
              a_n       = {a_q[6:0], f_q[F_CY]};
            end
            3'd3: begin
              f_n[F_CY] = a_q[0];
              a_n       = {f_q[F_CY], a_q[7:1]};
            end
            3'd4: begin
              // decimal adjust: low digit first, then the high digit
              if (a_q[3:0] > 4'd9 || f_q[F_AC]) begin
                corr = corr + 8'h06;
              end
              if (a_q[7:4] > 4'd9 || f_q[F_CY] ||
                  (a_q[7:4] >= 4'd9 && a_q[3:0] > 4'd9)) begin
                corr = corr + 8'h60;
                cy   = 1'b1;
              end
              s5        = {1'b0, a_q[3:0]} + {1'b0, corr[3:0]};
              f_n[F_AC] = s5[4];
              a_n       = a_q + corr;
              f_n[F_CY] = cy;
              f_n       = set_szp(f_n, a_n);
            end
            3'd5: a_n = ~a_q;
            3'd6: f_n[F_CY] = 1'b1;
            default: f_n[F_CY] = ~f_q[F_CY];
          endcase
        end
      endcase
    end else if (grp_mov) begin
      if (op_q == OP_HLT) begin
        halt_n = 1'b1;
        cyc_n  = 5'd7;
      end else begin
        rw_en = 1'b1;
        rw_v  = src8;
        cyc_n = (dst == REG_M || lo3 == REG_M) ? 5'd7 : 5'd5;
      end
    end else begin
      cyc_n = (lo3 == REG_M) ? 5'd7 : 5'd4;
      if (dst[2:1] == 2'b00) begin
        cin       = dst[0] & f_q[F_CY];
        s9        = {1'b0, a_q} + {1'b0, src8} + {8'h00, cin};
        s5        = {1'b0, a_q[3:0]} + {1'b0, src8[3:0]} + {4'h0, cin};
        f_n[F_AC] = s5[4];
        f_n[F_CY] = s9[8];
        a_n       = s9[7:0];
      end else begin
        s5        = {1'b0, a_q[3:0]} + {1'b0, ~src8[3:0]} + 5'd1;
        f_n[F_AC] = s5[4];
        f_n[F_CY] = src8 > a_q;
        a_n       = a_q - src8;
      end
      f_n = set_szp(f_n, a_n);
    end

    if (rw_en) begin
      case (rw_i)
        3'd0:    b_n = rw_v;
        3'd1:    c_n = rw_v;
        3'd2:    d_n = rw_v;
        3'd3:    e_n = rw_v;
        3'd4:    h_n = rw_v;
        3'd5:    l_n = rw_v;
        REG_M: begin
          ex_we = 1'b1;
          ex_wv = rw_v;
        end
        default: a_n = rw_v;
      endcase
    end
    if (pw_en) begin
      case (pw_i)
        2'd0:    {b_n, c_n} = pw_v;
        2'd1:    {d_n, e_n} = pw_v;
        2'd2:    {h_n, l_n} = pw_v;
        default: sp_n = pw_v;
      endcase
    end
    pc_n = pc_q + {14'd0, len};
  end

  // memory port
  logic [15:0]          maddr;
  logic [ADDR_BITS-1:0] ma;
  logic                 mem_we;
  logic [7:0]           mem_wv;

  always_comb begin
    case (cmd_i.asel)
      ASEL_IN:  maddr = addr_q;
      ASEL_PC:  maddr = pc_q;
      ASEL_PC1: maddr = pc_q + 16'd1;
      ASEL_PC2: maddr = pc_q + 16'd2;
      ASEL_D:   maddr = daddr;
      ASEL_D1:  maddr = daddr + 16'd1;
      default:  maddr = pc_q;
    endcase
  end

  assign ma     = maddr[ADDR_BITS-1:0];
  assign mem_we = cmd_i.wr_in || cmd_i.wr2 || (cmd_i.exec && !unsup && ex_we);
  assign mem_wv = cmd_i.wr_in ? wb_q : (cmd_i.wr2 ? h_q : ex_wv);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ma] <= mem_wv;
    end else begin
      rdata_q <= mem[ma];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      sp_q   <= '0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      e_q    <= '0;
      h_q    <= '0;
      l_q    <= '0;
      f_q    <= '0;
      halt_q <= 1'b0;
      trap_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        trap_q <= cfg_wdata_i;
      end
      if (cmd_i.exec && !unsup) begin
        pc_q   <= pc_n;
        sp_q   <= sp_n;
        a_q    <= a_n;
        b_q    <= b_n;
        c_q    <= c_n;
        d_q    <= d_n;
        e_q    <= e_n;
        h_q    <= h_n;
        l_q    <= l_n;
        f_q    <= f_n;
        halt_q <= halt_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= in_addr_i;
      wb_q   <= in_byte_i;
      cyc_q  <= '0;
      rd_q   <= '0;
      st_q   <= (cmd_e'(in_cmd_i) == CMD_EXEC && halt_q) ? ST_HALTED : ST_DONE;
    end
    if (cmd_i.lat_rd)     rd_q         <= rdata_q;
    if (cmd_i.lat_op)     op_q         <= rdata_q;
    if (cmd_i.lat_imm_lo) imm_q[7:0]   <= rdata_q;
    if (cmd_i.lat_imm_hi) imm_q[15:8]  <= rdata_q;
    if (cmd_i.lat_dat_lo) dat_q[7:0]   <= rdata_q;
    if (cmd_i.lat_dat_hi) dat_q[15:8]  <= rdata_q;
    if (cmd_i.exec) begin
      if (unsup) begin
        st_q <= ST_UNSUP;
      end else begin
        cyc_q <= cyc_n;
      end
    end
  end

  assign res_o = {4'h0, st_q, rd_q, cyc_q, f_q, h_q, l_q, d_q, e_q, b_q, c_q, a_q, sp_q, pc_q};

endmodule

// File: hdl/eight_bit_cpu_instruction_step_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_step_unit
// Steps one 8-bit CPU instruction or one memory access per beat.
// ----------------------------------------------------------------------------
// Memory write, memory read and execute each take their own path through the
// sequencer from accept to result, the execute path set by the reads through the
// single memory port; an execute while halted and the unused command go straight to the result.
// One beat at a time; the next beat is taken the cycle after the
// result is taken. Reset clears the architectural registers, flags, halt and the trap bit;
// memory contents are undefined until written.
module eight_bit_cpu_instruction_step_unit import ecpu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // mem_address[15:0], write_byte[23:16]
  input  logic [1:0]          s_axis_tuser,  // cmd[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // prog_counter, stack_ptr, accum, pair_bc, pair_de, pair_hl, flag_bits,
  // step_cycles, read_byte, status
  output logic [RES_BITS-1:0] m_axis_tdata
);

  ecpu_cmd_t  cmd;
  ecpu_stat_t stat;

  ecpu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ecpu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[15:0]),
    .in_byte_i   (s_axis_tdata[23:16]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (m_axis_tdata)
  );

endmodule

// File: hdl/ecpu_checker.sv
// ----------------------------------------------------------------------------
// ecpu_checker
// Port-level checks of the step unit, bound to the top level.
// ----------------------------------------------------------------------------
module ecpu_checker import ecpu_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [RES_BITS-1:0] m_axis_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result waits");

  a_no_ready_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken before result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[107:106] != 2'd3)
    else $error("bad status code");

  a_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[107:106] != 2'd0 |-> m_axis_tdata[97:93] == 5'd0)
    else $error("cycle count on a step that did not run");

endmodule

bind eight_bit_cpu_instruction_step_unit ecpu_checker u_ecpu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
